// File: hdl/dni_pkg.sv
// shared types, constants and the cordic arctangent table of the needle interpolator
// no dependencies
package dni_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // radius gain compensation, K in Q30
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_RADIUS      = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] angle;
    } entry_t;

    // atan(2^-i), 2^32 steps per turn
    function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        begin
            case (5'(i))
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/dni_ram.sv
// generic single-port ram with registered read
// no dependencies
module dni_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hdl/dial_needle_interpolator_core.sv
// dial needle interpolator: breakpoint table, segment search, divider and cordic
// depends on dni_pkg and dni_ram
// load transaction: written to the table in idle, no result; evaluate transaction: a clamped
// value goes straight to the cordic, an interpolated one first scans the segments over the
// single table ram port, then runs the 17-step divider and the 16-step cordic; the input is
// ready again in the same cycle that the result becomes valid; one item at a time; a finished
// result waits in the output register while the next is taken, and a full output register
// stalls the final state
// reset clears control and config (entry_count 2, radius 1.0); table contents undefined
module dial_needle_interpolator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // entry_index, entry_value, entry_angle, dial_value, pad
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // needle_x, needle_y, pad
    output logic        m_axis_tuser,  // found
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import dni_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RDL   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SRD   = 4'd4;
    localparam logic [3:0] S_SCMP  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_CINIT = 4'd9;
    localparam logic [3:0] S_CSET  = 4'd10;
    localparam logic [3:0] S_CROT  = 4'd11;
    localparam logic [3:0] S_COUT  = 4'd12;

    logic [3:0] state_reg, state_next;

    // config
    logic [6:0]  entry_count_reg;
    logic [15:0] radius_reg;

    // input fields
    logic [5:0]  in_index;
    logic [31:0] in_value;
    logic [15:0] in_angle;
    logic [31:0] in_dial;
    logic        in_accept;

    // table ram
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    entry_t           ram_wdata, ram_rdata;

    // search
    logic signed [31:0] d_reg;
    logic [IDX_W-1:0]   last_reg, k_reg;
    logic [6:0]         n_eff;
    entry_t             prev_reg;
    logic               hit;

    // divider
    logic [15:0] mag_reg, ai_reg;
    logic [31:0] num_reg, den_reg;
    logic [47:0] prod_reg;
    logic [49:0] rem_reg, dsh_reg;
    logic [16:0] q_reg, q_new;
    logic [4:0]  dcnt_reg;
    logic        qbit;
    logic signed [17:0] delta;
    logic [15:0] mag_c;

    // cordic
    logic [15:0]        ang_reg;
    logic [45:0]        xmul_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg, y_reg, xs;
    logic signed [32:0] z_reg, za, zf;
    logic [STEP_W-1:0]  step_reg;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;

    // output
    logic               out_valid_reg;
    logic [16:0]        out_x_reg, out_y_reg;
    logic signed [19:0] xr, yr, yn;
    logic [16:0]        x_sat, y_sat;
    logic               out_free;

    assign in_index  = s_axis_tdata[5:0];
    assign in_value  = s_axis_tdata[37:6];
    assign in_angle  = s_axis_tdata[53:38];
    assign in_dial   = s_axis_tdata[85:54];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // count clamped to [2, depth]
    always_comb
    begin
        if (entry_count_reg < 7'd2)
            n_eff = 7'd2;
        else if (9'(entry_count_reg) > 9'(TABLE_DEPTH))
            n_eff = 7'(TABLE_DEPTH);
        else
            n_eff = entry_count_reg;
    end

    // table port: write address in idle, search address otherwise
    always_comb
    begin
        ram_we    = in_accept && (s_axis_tuser == ACT_LOAD)
                    && (9'(in_index) < 9'(TABLE_DEPTH));
        ram_wdata = '{value: in_value, angle: in_angle};
        case (state_reg)
            S_IDLE:  ram_addr = IDX_W'(in_index);
            S_RD0:   ram_addr = '0;
            S_RDL:   ram_addr = last_reg;
            default: ram_addr = k_reg;
        endcase
    end

    dni_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // segment match, last slot taken as match so the scan always ends
    assign hit = ((d_reg >= $signed(prev_reg.value)) && (d_reg < $signed(ram_rdata.value)))
                 || (k_reg == last_reg);

    // segment runs negative: positive step loses a turn
    always_comb
    begin
        delta = 18'(signed'(ram_rdata.angle)) - 18'(signed'(prev_reg.angle));
        if (delta > 18'sd0)
            delta = delta - 18'sd65536;
        mag_c = 16'(-delta);
    end

    // restoring divider step
    assign qbit  = (rem_reg >= dsh_reg);
    assign q_new = {q_reg[15:0], qbit};

    // angle to 2^32 per turn, folded to within a quarter turn
    always_comb
    begin
        za = 33'(signed'(ang_reg)) <<< 16;
        if (za > 33'sd1073741824)
            zf = za - 33'sd2147483648;
        else if (za < -33'sd1073741824)
            zf = za + 33'sd2147483648;
        else
            zf = za;
    end

    assign xs = 34'(xmul_reg[45:16]);
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = 33'(atan_step(step_reg));

    // output rounding and saturation
    always_comb
    begin
        xr = 20'((x_reg + 34'sd8192) >>> 14);
        yr = 20'((y_reg + 34'sd8192) >>> 14);
        yn = -yr;
        if (xr > 20'sd65535)
            x_sat = 17'd65535;
        else if (xr < -20'sd65535)
            x_sat = 17'(-20'sd65535);
        else
            x_sat = xr[16:0];
        if (yn > 20'sd65535)
            y_sat = 17'd65535;
        else if (yn < -20'sd65535)
            y_sat = 17'(-20'sd65535);
        else
            y_sat = yn[16:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (s_axis_tuser == ACT_EVAL))
                    state_next = S_RD0;
            end
            S_RD0:   state_next = S_RDL;
            S_RDL:   state_next = S_CHK;
            S_CHK:
            begin
                if ((d_reg <= $signed(prev_reg.value)) || (d_reg >= $signed(ram_rdata.value)))
                    state_next = S_CINIT;
                else
                    state_next = S_SRD;
            end
            S_SRD:   state_next = S_SCMP;
            S_SCMP:  state_next = hit ? S_MUL : S_SRD;
            S_MUL:   state_next = S_DIVI;
            S_DIVI:  state_next = S_DIV;
            S_DIV:
            begin
                if (dcnt_reg == 5'd0)
                    state_next = S_CINIT;
            end
            S_CINIT: state_next = S_CSET;
            S_CSET:  state_next = S_CROT;
            S_CROT:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = S_COUT;
            end
            S_COUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= 7'd2;
            radius_reg      <= 16'd256;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENTRY_COUNT: entry_count_reg <= cfg_data[6:0];
                    REG_RADIUS:      radius_reg      <= cfg_data;
                    default:         ;
                endcase
            end
            if (state_reg == S_COUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                d_reg    <= signed'(in_dial);
                last_reg <= IDX_W'(n_eff - 7'd1);
            end
            S_RDL:   prev_reg <= ram_rdata;
            S_CHK:
            begin
                k_reg <= IDX_W'(1);
                if (d_reg <= $signed(prev_reg.value))
                    ang_reg <= prev_reg.angle;
                else
                    ang_reg <= ram_rdata.angle;
            end
            S_SCMP:
            begin
                prev_reg <= ram_rdata;
                k_reg    <= k_reg + IDX_W'(1);
                mag_reg  <= mag_c;
                ai_reg   <= prev_reg.angle;
                num_reg  <= 32'(d_reg) - prev_reg.value;
                den_reg  <= ram_rdata.value - prev_reg.value;
            end
            S_MUL:   prod_reg <= 48'(mag_reg) * 48'(num_reg);
            S_DIVI:
            begin
                rem_reg  <= {1'b0, prod_reg, 1'b0} + 50'(den_reg);
                dsh_reg  <= 50'({den_reg, 1'b0}) << 16;
                q_reg    <= '0;
                dcnt_reg <= 5'd16;
            end
            S_DIV:
            begin
                if (qbit)
                    rem_reg <= rem_reg - dsh_reg;
                dsh_reg  <= dsh_reg >> 1;
                q_reg    <= q_new;
                dcnt_reg <= dcnt_reg - 5'd1;
                ang_reg  <= ai_reg - q_new[15:0];
            end
            S_CINIT:
            begin
                xmul_reg <= 46'(radius_reg) * 46'(GAIN_Q30);
                z_reg    <= zf;
                neg_reg  <= (zf != za);
            end
            S_CSET:
            begin
                x_reg    <= neg_reg ? -xs : xs;
                y_reg    <= '0;
                step_reg <= '0;
            end
            S_CROT:
            begin
                if (z_reg >= 33'sd0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            S_COUT:
            begin
                if (out_free)
                begin
                    out_x_reg <= x_sat;
                    out_y_reg <= y_sat;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_y_reg, out_x_reg};
    // a clamp or a segment always matches
    assign m_axis_tuser  = 1'b1;

    // table writes only happen while no evaluate transaction is in flight
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("table write outside idle");

    // an accepted evaluate transaction blocks the input next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == ACT_EVAL)) |=> !s_axis_tready)
        else $error("input ready while evaluating");

    // a load transaction never produces a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == ACT_LOAD) && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result from load");

    // result is loaded only from the final state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_COUT))
        else $error("result without cordic");

endmodule

// File: tb/dial_needle_interpolator_core_tb.sv
// self-checking testbench for the dial needle interpolator: breakpoint loads, segment
// interpolation, clamps and cordic needle output checked against a built-in predictor
// depends on dni_pkg and dial_needle_interpolator_core
`timescale 1ns / 1ps

module dial_needle_interpolator_core_tb;
    import dni_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  SETTLE      = 200;      // longer than the worst evaluate
    localparam int  CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic               found;
    } needle_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;   // entry_index, entry_value, entry_angle, dial_value, pad
    logic        s_axis_tuser = 1'b0; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // needle_x, needle_y, pad
    logic        m_axis_tuser;        // found
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    dial_needle_interpolator_core uut (.*);

    always #HALF_PERIOD clk = ~clk;

    // predictor state: breakpoint table and register copies
    logic [31:0] dial_tab [TABLE_DEPTH];
    logic [15:0] ang_tab [TABLE_DEPTH];
    logic [6:0]  count_reg = 7'd2;
    logic [15:0] radius_reg = 16'd256;

    needle_t needle_q [$];
    int      send_idle = 0;
    int      recv_idle = 0;
    int      errors = 0;
    int      loads = 0;
    int      evals = 0;
    int      results = 0;
    int      cfg_writes = 0;
    int      cycles = 0;

    // atan(2^-i), 2^32 steps per turn
    localparam longint ARCTAN [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

    function automatic logic signed [16:0] sat_q88(longint v);
        if (v > 65535)
            return 17'sd65535;
        if (v < -65535)
            return -17'sd65535;
        return v[16:0];
    endfunction

    // rotation-mode cordic on the folded angle
    function automatic needle_t rotate_needle(logic [15:0] ang);
        longint  z;
        longint  x;
        longint  y;
        longint  dx;
        longint  dy;
        needle_t r;
        z = longint'($signed(ang)) * 65536;
        x = longint'((longint'(radius_reg) * longint'(GAIN_Q30)) >> 16);
        y = 0;
        if (z > (64'sd1 <<< 30))
        begin
            z -= (64'sd1 <<< 31);
            x = -x;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z += (64'sd1 <<< 31);
            x = -x;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ARCTAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ARCTAN[i];
            end
        end
        r.x = sat_q88((x + 8192) >>> 14);
        r.y = sat_q88(-((y + 8192) >>> 14));
        r.found = 1'b1;
        return r;
    endfunction

    // segment search, clamps and rounded interpolation
    function automatic needle_t predict_needle(logic signed [31:0] d);
        int      n;
        longint  vi;
        longint  vj;
        longint  ai;
        longint  delta;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        logic [15:0] ang;
        n = count_reg;
        if (n < 2)
            n = 2;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        ang = '0;
        if (d <= $signed(dial_tab[0]))
            ang = ang_tab[0];
        else if (d >= $signed(dial_tab[n-1]))
            ang = ang_tab[n-1];
        else
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                vi = $signed(dial_tab[i]);
                vj = $signed(dial_tab[i+1]);
                if (d >= vi && d < vj)
                begin
                    ai = $signed(ang_tab[i]);
                    delta = longint'($signed(ang_tab[i+1])) - ai;
                    // segment always turns negative
                    if (delta > 0)
                        delta -= 65536;
                    mag = -delta;
                    num = longint'(d) - vi;
                    den = vj - vi;
                    q = (2 * mag * num + den) / (2 * den);
                    ang = 16'(ai - longint'(q));
                    break;
                end
            end
        end
        return rotate_needle(ang);
    endfunction

    // one input transaction; called and returns at a falling edge
    task automatic send_item(logic act, logic [5:0] idx, logic [31:0] val,
                             logic [15:0] ang, logic [31:0] dial);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = act;
        s_axis_tdata = {2'b00, dial, ang, val, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (act == ACT_LOAD)
        begin
            dial_tab[idx] = val;
            ang_tab[idx] = ang;
            loads++;
        end
        else
        begin
            needle_q.push_back(predict_needle(dial));
            evals++;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic load_entry(int idx, logic [31:0] val, logic [15:0] ang);
        send_item(ACT_LOAD, 6'(idx), val, ang, $urandom);
    endtask

    task automatic eval_dial(logic [31:0] d);
        send_item(ACT_EVAL, 6'($urandom), $urandom, 16'($urandom), d);
    endtask

    // wait for all results, then let a trailing evaluate finish
    task automatic drain();
        while (needle_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_ENTRY_COUNT)
            count_reg = data[6:0];
        else
            radius_reg = data;
        cfg_writes++;
    endtask

    // result checker: compares each output transaction with the oldest expectation
    always @(posedge clk)
    begin
        needle_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results++;
            if (needle_q.size() == 0)
            begin
                $error("unexpected result transaction x=%0d y=%0d",
                       $signed(m_axis_tdata[16:0]), $signed(m_axis_tdata[33:17]));
                errors++;
            end
            else
            begin
                e = needle_q.pop_front();
                if (m_axis_tdata[16:0] !== e.x)
                begin
                    $error("needle_x expected %0d actual %0d", e.x, $signed(m_axis_tdata[16:0]));
                    errors++;
                end
                if (m_axis_tdata[33:17] !== e.y)
                begin
                    $error("needle_y expected %0d actual %0d", e.y, $signed(m_axis_tdata[33:17]));
                    errors++;
                end
                if (m_axis_tuser !== e.found)
                begin
                    $error("found expected %0d actual %0d", e.found, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // every slot gets a defined entry before any evaluate reads it
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(i, 32'(i * 4096), 16'(-i * 256));
    endtask

    task automatic test_directed();
        // widest segment, angles at the extremes, positive step wraps a turn
        load_entry(0, 32'h8000_0000, 16'h8000);
        load_entry(1, 32'h7FFF_FFFF, 16'h7FFF);
        eval_dial(32'h8000_0000);           // low clamp
        eval_dial(32'h7FFF_FFFF);           // high clamp
        eval_dial(32'h0000_0000);           // interpolated
        eval_dial(32'h7FFF_FFFE);
        write_reg(REG_RADIUS, 16'hFFFF);
        eval_dial(32'h4000_0000);
        write_reg(REG_RADIUS, 16'h0000);
        eval_dial(32'h1234_5678);
        write_reg(REG_RADIUS, 16'd256);
        // count below two acts as two
        write_reg(REG_ENTRY_COUNT, 16'd0);
        eval_dial(32'hC000_0000);
        // non-monotonic table: first matching segment wins
        load_entry(0, 32'd0, 16'd1000);
        load_entry(1, 32'd100, 16'd0);
        load_entry(2, 32'd50, 16'd20000);
        load_entry(3, 32'd200, 16'hC000);
        write_reg(REG_ENTRY_COUNT, 16'd4);
        eval_dial(32'd75);
        eval_dial(32'd150);
        // count beyond the table depth acts as the depth
        write_reg(REG_ENTRY_COUNT, 16'd127);
        eval_dial(32'd120000);
        write_reg(REG_ENTRY_COUNT, 16'd64);
        eval_dial(32'h7FFF_FFFF);
    endtask

    // one well-formed table of n non-decreasing breakpoints, then evaluates across it
    task automatic table_round(int n, int evals_per);
        longint v;
        longint lo;
        longint hi;
        longint d;
        longint step_max;
        step_max = 64'h1_0000_0000 / n;
        if ($urandom_range(1))
            step_max = $urandom_range(1, 5000);  // narrow segments
        v = -longint'(64'h8000_0000) + $urandom_range(0, 32'hFFFF_FFFF - step_max * (n - 1));
        lo = v;
        write_reg(REG_ENTRY_COUNT, 16'(n));
        if ($urandom_range(3) == 0)
            write_reg(REG_RADIUS, 16'($urandom));
        for (int i = 0; i < n; i++)
        begin
            load_entry(i, 32'(v), 16'($urandom));
            hi = v;
            if (i + 1 < n)
                v += $urandom_range(0, 32'(step_max));
        end
        for (int k = 0; k < evals_per; k++)
        begin
            d = lo + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (hi - lo + 3) - 1;
            if ($urandom_range(7) == 0)
                d = longint'($signed(32'($urandom)));
            if (d > 64'sh7FFF_FFFF)
                d = 64'sh7FFF_FFFF;
            if (d < -64'sh8000_0000)
                d = -64'sh8000_0000;
            eval_dial(32'(d));
        end
        // noise: a stray load of a random entry into a random slot, then a random evaluate
        if ($urandom_range(4) == 0)
        begin
            load_entry($urandom_range(0, 63), $urandom, 16'($urandom));
            eval_dial($urandom);
        end
    endtask

    task automatic test_random(int budget);
        int start;
        start = loads + evals;
        while (loads + evals - start < budget)
        begin
            if ($urandom_range(3) == 0)
                table_round($urandom_range(2, 64), $urandom_range(4, 12));
            else
                table_round($urandom_range(2, 8), $urandom_range(4, 12));
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_table_fill();
        test_directed();
        drain();            // sender holds off until every result is back

        send_idle = 37;
        recv_idle = 86;
        test_random(165);
        send_idle = 86;
        recv_idle = 37;
        test_random(165);
        send_idle = 0;
        recv_idle = 0;
        test_random(185);
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_ENTRY_COUNT, 16'd64);
        eval_dial($urandom);

        drain();
        $display("covered %0d load and %0d evaluate transactions, %0d results checked,",
                 loads, evals, results);
        $display("%0d register writes across count and radius settings", cfg_writes);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
